// ===== rtl/core/imu_angle_frame_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle frame parser
// Shared property wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef IMU_ANGLE_FRAME_PARSER_DEFINES_SVH
`define IMU_ANGLE_FRAME_PARSER_DEFINES_SVH

// checked only outside reset
`define IAFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define IAFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/iafp_pkg.sv =====
// ----------------------------------------------------------------------------
// iafp_pkg
// Types and constants of the angle frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iafp_pkg;

  localparam int          FRAME_LEN   = 11;
  localparam int          CNT_W       = 4;
  localparam logic [3:0]  LAST_IDX    = 4'(FRAME_LEN - 1);
  localparam logic [3:0]  YAW_LO_POS  = 4'd6;
  localparam logic [3:0]  YAW_HI_POS  = 4'd7;
  localparam logic [7:0]  START_BYTE  = 8'h55;
  localparam logic [7:0]  TYPE_RESET  = 8'h53;

  localparam int          DATA_W      = 32;
  localparam int          ADDR_W      = 3;
  // register index, taken from paddr[2]
  localparam logic        REG_FRAME_TYPE = 1'b0;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

endpackage

// ===== rtl/core/iafp_if.sv =====
// ----------------------------------------------------------------------------
// iafp_if
// Valid/ready channels: received bytes in, yaw results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iafp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iafp_yaw_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;

  modport source (output valid, output yaw_angle, input ready);
  modport sink   (input valid, input yaw_angle, output ready);
endinterface

// ===== rtl/core/imu_angle_frame_parser.sv =====
// ----------------------------------------------------------------------------
// imu_angle_frame_parser: one byte per cycle, sustained, through one parser step.
// Flow: a byte is registered in the input register, then parsed; when the checksum
// byte of a good frame is parsed, yaw is registered in the result register. Output backpressure stalls the parser step.
// Reset (async, low): hunt for start byte, sums cleared, frame_type = 0x53.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imu_angle_frame_parser_defines.svh"

module imu_angle_frame_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  iafp_byte_if.sink                   rx_i,
  iafp_yaw_if.source                  yaw_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [iafp_pkg::ADDR_W-1:0] paddr_i,
  input  logic [iafp_pkg::DATA_W-1:0] pwdata_i,
  output logic [iafp_pkg::DATA_W-1:0] prdata_o,
  output logic                        pready_o
);

  logic [7:0]                  frame_type_q;
  logic                        in_valid_q;
  logic [7:0]                  in_byte_q;
  iafp_pkg::phase_e            phase_q, phase_d;
  logic [iafp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]                  sum_q, sum_d;
  logic [7:0]                  yaw_lo_q, yaw_lo_d;
  logic [7:0]                  yaw_hi_q, yaw_hi_d;
  logic                        out_valid_q;
  logic signed [15:0]          yaw_q;
  logic                        advance, step, emit, cfg_wr;

  // ---- configuration ----
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_type_q <= iafp_pkg::TYPE_RESET;
    end else if (cfg_wr && paddr_i[2] == iafp_pkg::REG_FRAME_TYPE) begin
      frame_type_q <= pwdata_i[7:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == iafp_pkg::REG_FRAME_TYPE) begin
      prdata_o = {{(iafp_pkg::DATA_W-8){1'b0}}, frame_type_q};
    end
  end

  // ---- input register ----
  assign advance  = !out_valid_q || yaw_o.ready;
  assign step     = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // ---- parser: next phase ----
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      iafp_pkg::PH_TYPE: begin
        if (in_byte_q == frame_type_q) phase_d = iafp_pkg::PH_COLLECT;
      end
      iafp_pkg::PH_COLLECT: begin
        if (cnt_q >= iafp_pkg::LAST_IDX) phase_d = iafp_pkg::PH_HUNT;
      end
      default: begin
        phase_d = (in_byte_q == iafp_pkg::START_BYTE) ? iafp_pkg::PH_TYPE
                                                      : iafp_pkg::PH_HUNT;
      end
    endcase
  end

  // ---- parser: count, checksum, captured bytes ----
  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    yaw_lo_d = yaw_lo_q;
    yaw_hi_d = yaw_hi_q;
    emit     = 1'b0;
    unique case (phase_q)
      iafp_pkg::PH_TYPE: begin
        if (in_byte_q == frame_type_q) begin
          sum_d = sum_q + in_byte_q;
          cnt_d = 4'd2;
        end
      end
      iafp_pkg::PH_COLLECT: begin
        if (cnt_q == iafp_pkg::YAW_LO_POS) yaw_lo_d = in_byte_q;
        if (cnt_q == iafp_pkg::YAW_HI_POS) yaw_hi_d = in_byte_q;
        if (cnt_q >= iafp_pkg::LAST_IDX) begin
          emit  = (sum_q == in_byte_q);
          cnt_d = '0;
          sum_d = '0;
        end else begin
          sum_d = sum_q + in_byte_q;
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: begin
        if (in_byte_q == iafp_pkg::START_BYTE) begin
          sum_d = in_byte_q;
          cnt_d = 4'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= iafp_pkg::PH_HUNT;
      cnt_q    <= '0;
      sum_q    <= '0;
      yaw_lo_q <= '0;
      yaw_hi_q <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      yaw_lo_q <= yaw_lo_d;
      yaw_hi_q <= yaw_hi_d;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (yaw_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // low and high bytes are captured at frame positions 6 and 7, before the checksum byte
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      yaw_q <= $signed({yaw_hi_d, yaw_lo_d});
    end
  end

  assign yaw_o.valid     = out_valid_q;
  assign yaw_o.yaw_angle = yaw_q;

  // ---- assertions ----
  `IAFP_ASSERT(a_result_from_collect, $rose(out_valid_q) |-> $past(phase_q == iafp_pkg::PH_COLLECT), "result not from a frame end")
  `IAFP_ASSERT_ALWAYS(a_hunt_clean, (phase_q == iafp_pkg::PH_HUNT) |-> (cnt_q == '0 && sum_q == '0), "hunt state not clean")
  `IAFP_ASSERT(a_collect_range, (phase_q == iafp_pkg::PH_COLLECT) |-> (cnt_q >= 4'd2 && cnt_q <= iafp_pkg::LAST_IDX), "byte count out of frame")
  `IAFP_ASSERT(a_stall_cause, !rx_i.ready |-> (in_valid_q && out_valid_q && !yaw_o.ready), "input stalled without cause")

endmodule

// ===== test/imu_angle_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_tb
// Feeds byte requests into the frame parser, with directed frames, then random
// traffic of good, bad-checksum, wrong-type and truncated frames plus line
// noise, under several frame_type settings. A local parser model predicts each
// yaw result, and the monitor checks every yaw request against it, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_angle_frame_parser_tb;

  localparam int CLK_HALF         = 10;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 205;

  localparam logic [iafp_pkg::ADDR_W-1:0] TYPE_ADDR =
    iafp_pkg::ADDR_W'({iafp_pkg::REG_FRAME_TYPE, 2'b00});

  // data bytes between the header and the checksum
  typedef logic [7:0] body_t [iafp_pkg::FRAME_LEN-3];

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        psel_i;
  logic                        penable_i;
  logic                        pwrite_i;
  logic [iafp_pkg::ADDR_W-1:0] paddr_i;
  logic [iafp_pkg::DATA_W-1:0] pwdata_i;
  logic [iafp_pkg::DATA_W-1:0] prdata_o;
  logic                        pready_o;

  iafp_byte_if rx_if ();
  iafp_yaw_if  yaw_if ();

  imu_angle_frame_parser u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_if),
    .yaw_o     (yaw_if),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // parser model state and its copy of the register
  logic [7:0]       type_cfg;
  iafp_pkg::phase_e model_phase;
  logic [3:0]       model_idx;
  logic [7:0]       model_sum;
  logic [7:0]       model_lo;
  logic [7:0]       model_hi;

  logic [7:0]         byte_q [$];
  logic signed [15:0] yaw_expected [$];
  int                 n_pushed;
  int                 errors;
  int                 cycles;

  bit rx_took;
  int src_gap;
  bit src_burst;
  int sink_gap;
  bit sink_burst;
  bit hold_armed;
  int hold_left;

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("ERROR at %0t: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    errors++;
  endtask

  // one parser step; returns 1 when the byte completes a frame with a good checksum
  function automatic bit parse_byte(input logic [7:0] b, output logic signed [15:0] yaw);
    bit hit;
    hit = 1'b0;
    yaw = '0;
    case (model_phase)
      iafp_pkg::PH_TYPE: begin
        // wrong type bytes are skipped, the hunt is not restarted
        if (b == type_cfg) begin
          model_sum   = model_sum + b;
          model_idx   = 4'd2;
          model_phase = iafp_pkg::PH_COLLECT;
        end
      end
      iafp_pkg::PH_COLLECT: begin
        if (model_idx == iafp_pkg::YAW_LO_POS) model_lo = b;
        if (model_idx == iafp_pkg::YAW_HI_POS) model_hi = b;
        if (model_idx >= iafp_pkg::LAST_IDX) begin
          hit         = (model_sum == b);
          yaw         = {model_hi, model_lo};
          model_phase = iafp_pkg::PH_HUNT;
          model_idx   = '0;
          model_sum   = '0;
        end else begin
          model_sum = model_sum + b;
          model_idx = model_idx + 4'd1;
        end
      end
      default: begin
        model_phase = iafp_pkg::PH_HUNT;
        if (b == iafp_pkg::START_BYTE) begin
          model_sum   = b;
          model_idx   = 4'd1;
          model_phase = iafp_pkg::PH_TYPE;
        end
      end
    endcase
    return hit;
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_yaw();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    n_pushed++;
  endfunction

  // header, body and checksum; wrong type bytes go after the start byte,
  // and the frame may be cut short
  task automatic add_frame(input body_t body, input int wrong_types, input bit bad_sum,
                           input int cut_at);
    logic [7:0] fr [iafp_pkg::FRAME_LEN];
    logic [7:0] sum;
    logic [7:0] junk;
    fr[0] = iafp_pkg::START_BYTE;
    fr[1] = type_cfg;
    foreach (body[i]) fr[i+2] = body[i];
    sum = '0;
    for (int i = 0; i < iafp_pkg::FRAME_LEN - 1; i++) sum = sum + fr[i];
    fr[iafp_pkg::FRAME_LEN-1] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < cut_at; i++) begin
      push_byte(fr[i]);
      if (i == 0) begin
        repeat (wrong_types) begin
          junk = 8'($urandom);
          if (junk == type_cfg) junk = junk ^ 8'h01;
          push_byte(junk);
        end
      end
    end
  endtask

  task automatic gen_traffic(input int n);
    int          target;
    int          r;
    body_t       body;
    logic [15:0] yaw;
    target = n_pushed + n;
    while (n_pushed < target) begin
      r = $urandom_range(0, 99);
      foreach (body[i]) body[i] = 8'($urandom);
      yaw = pick_yaw();
      body[iafp_pkg::YAW_LO_POS-2] = yaw[7:0];
      body[iafp_pkg::YAW_HI_POS-2] = yaw[15:8];
      if (r < 62)      add_frame(body, 0, 1'b0, iafp_pkg::FRAME_LEN);
      else if (r < 72) add_frame(body, 0, 1'b1, iafp_pkg::FRAME_LEN);
      else if (r < 82) add_frame(body, $urandom_range(1, 3), 1'b0, iafp_pkg::FRAME_LEN);
      else if (r < 90) add_frame(body, 0, 1'b0, $urandom_range(2, iafp_pkg::FRAME_LEN - 1));
      else repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end
  endtask

  // write frame_type, then read it back
  task automatic write_frame_type(input logic [7:0] value);
    logic [iafp_pkg::DATA_W-1:0] rd;
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= TYPE_ADDR;
    pwdata_i  <= iafp_pkg::DATA_W'(value);
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rd = prdata_o;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    type_cfg = value;
    if (rd[7:0] !== value) report_mismatch("frame_type readback", int'(value), int'(rd[7:0]));
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || rx_if.valid || yaw_expected.size() != 0) @(posedge clk_i);
    // a byte with no result may still be inside the parser
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // byte source
  always @(negedge clk_i) begin
    if (rst_ni && (!rx_if.valid || rx_took)) begin
      if (src_gap > 0) begin
        rx_if.valid <= 1'b0;
        src_gap--;
      end else if (byte_q.size() > 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= byte_q.pop_front();
        src_gap = pick_gap(src_burst);
        if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // yaw sink, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      yaw_if.ready <= 1'b0;
    end else begin
      if (hold_armed) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        yaw_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        yaw_if.ready <= 1'b0;
      end else begin
        yaw_if.ready <= 1'b1;
        sink_gap = pick_gap(sink_burst);
        if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    logic signed [15:0] yaw_pred;
    logic signed [15:0] yaw_want;
    rx_took = rx_if.valid && rx_if.ready;
    if (rst_ni) begin
      if (yaw_if.valid && yaw_if.ready) begin
        if (yaw_expected.size() == 0) begin
          report_mismatch("unexpected yaw request", 0, int'(yaw_if.yaw_angle));
        end else begin
          yaw_want = yaw_expected.pop_front();
          if (yaw_if.yaw_angle !== yaw_want)
            report_mismatch("yaw_angle", int'(yaw_want), int'(yaw_if.yaw_angle));
        end
      end
      if (rx_took && parse_byte(rx_if.rx_byte, yaw_pred)) yaw_expected.push_back(yaw_pred);
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    body_t      body;
    logic [7:0] types [4];
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    yaw_if.ready  = 1'b0;
    psel_i        = 1'b0;
    penable_i     = 1'b0;
    pwrite_i      = 1'b0;
    paddr_i       = '0;
    pwdata_i      = '0;
    type_cfg      = iafp_pkg::TYPE_RESET;
    model_phase   = iafp_pkg::PH_HUNT;
    model_idx     = '0;
    model_sum     = '0;
    model_lo      = '0;
    model_hi      = '0;
    n_pushed      = 0;
    errors        = 0;
    cycles        = 0;
    src_gap       = 0;
    sink_gap      = 0;
    hold_left     = 0;
    hold_armed    = 1'b0;
    src_burst     = 1'b0;
    sink_burst    = 1'b0;
    rx_took       = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_frame_type(iafp_pkg::TYPE_RESET);

    // directed: noise while hunting, a frame with wrong type bytes and a start
    // byte inside it (yaw at its negative extreme), then a bad checksum
    push_byte(8'hFF);
    body = '{iafp_pkg::START_BYTE, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h01};
    add_frame(body, 2, 1'b0, iafp_pkg::FRAME_LEN);
    body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'hFF};
    add_frame(body, 0, 1'b1, iafp_pkg::FRAME_LEN);
    gen_traffic(RANDOM_PER_PHASE);
    wait_idle();

    types = '{8'h00, 8'hFF, iafp_pkg::START_BYTE, 8'($urandom)};
    foreach (types[i]) begin
      write_frame_type(types[i]);
      gen_traffic(RANDOM_PER_PHASE);
      if (i == 1) begin
        @(posedge clk_i);
        hold_armed = 1'b1;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
